### hdl/function_call_profiler_table_core_assert.svh
// Assertion macros for the profiler table RTL.
`ifndef FUNCTION_CALL_PROFILER_TABLE_CORE_ASSERT_SVH
`define FUNCTION_CALL_PROFILER_TABLE_CORE_ASSERT_SVH

// Condition holding at every edge outside reset.
`define FCP_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define FCP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/fcpt_pkg.sv
`default_nettype none
package fcpt_pkg;
	localparam int unsigned NumSetsDef = 1024;
	localparam int unsigned NumWaysDef = 4;
	localparam int unsigned AddrW      = 48;
	localparam int unsigned TimeW      = 48;
	localparam int unsigned CallW      = 32;
	localparam int unsigned DepthW     = 16;
	localparam int unsigned IdxW       = 12;

	typedef enum logic [1:0] {
		ACT_ENTER = 2'd0,
		ACT_EXIT  = 2'd1,
		ACT_READ  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_UNMATCHED = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]        action;
		logic [AddrW-1:0]  func_addr;
		logic [TimeW-1:0]  timestamp_us;
		logic [IdxW-1:0]   slot_index;
	} in_word_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [AddrW-1:0]  entry_addr;
		logic [CallW-1:0]  call_count;
		logic [TimeW-1:0]  elapsed_us;
		logic [DepthW-1:0] nest_depth;
	} out_word_t;

	// Table entry contents (valid bit kept apart).
	typedef struct packed {
		logic [AddrW-1:0]  addr;
		logic [CallW-1:0]  calls;
		logic [DepthW-1:0] depth;
		logic [TimeW-1:0]  entry_time;
		logic [TimeW-1:0]  elapsed;
	} entry_t;
endpackage
`default_nettype wire

### hdl/fcpt_front.sv
`default_nettype none
// Accepts words and queues them toward the table engine (2-entry FIFO).
module fcpt_front (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      push,
	output logic                     full,
	input  wire fcpt_pkg::in_word_t  in_word,
	output logic                     q_valid,
	input  wire                      q_take,
	output fcpt_pkg::in_word_t       q_word
);
	fcpt_pkg::in_word_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       do_push, do_pop;

	assign full    = (cnt_q == 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_word  = mem_q[rp_q];
	assign do_push = push && !full;
	assign do_pop  = q_take && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wp_q <= ~wp_q;
			if (do_pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wp_q] <= in_word;
	end
endmodule
`default_nettype wire

### hdl/fcpt_back.sv
`default_nettype none
`include "function_call_profiler_table_core_assert.svh"
// Table engine: read all ways of a set, then compare, update and write back.
module fcpt_back #(
	parameter int unsigned NUM_SETS = fcpt_pkg::NumSetsDef,
	parameter int unsigned NUM_WAYS = fcpt_pkg::NumWaysDef
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      q_valid,
	output logic                     q_take,
	input  wire fcpt_pkg::in_word_t  q_word,
	output logic                     empty,
	input  wire                      pop,
	output fcpt_pkg::out_word_t      out_word
);
	localparam int unsigned SetW  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int unsigned WayW  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int unsigned Slots = NUM_SETS * NUM_WAYS;
	localparam int unsigned IdxW  = fcpt_pkg::IdxW;
	localparam int unsigned TimeW = fcpt_pkg::TimeW;
	localparam int unsigned CallW = fcpt_pkg::CallW;
	localparam int unsigned DepthW = fcpt_pkg::DepthW;
	localparam int unsigned SumW  = TimeW + 1;

	// One entry memory and one valid memory per way, all indexed by set.
	fcpt_pkg::entry_t ram_q [NUM_WAYS][NUM_SETS];
	logic             vmem_q [NUM_WAYS][NUM_SETS];

	typedef enum logic [1:0] {S_CLR, S_LOOK, S_UPD} st_t;
	st_t st_q;
	logic [SetW-1:0] clr_set_q;  // set being cleared after reset

	fcpt_pkg::in_word_t  op_s1;
	logic [SetW-1:0]     set_s1;
	logic                rdin_s1;  // read index in range
	fcpt_pkg::entry_t    rd_s2 [NUM_WAYS];
	logic [NUM_WAYS-1:0] vrd_s2;
	logic                outv_q;
	fcpt_pkg::out_word_t out_q;

	logic [SetW-1:0] set_in;
	logic [WayW-1:0] rway_in;
	logic            rin_in;
	logic            start;

	// Set and read-way selection for the incoming word.
	always_comb begin
		logic [IdxW:0] idx;
		idx     = {1'b0, q_word.slot_index};
		rin_in  = (32'(idx) < Slots);
		set_in  = '0;
		rway_in = '0;
		if (q_word.action == fcpt_pkg::ACT_READ) begin
			set_in  = SetW'(32'(idx) / NUM_WAYS);
			rway_in = WayW'(32'(idx) % NUM_WAYS);
		end else begin
			set_in  = SetW'(q_word.func_addr % NUM_SETS);
		end
	end

	assign start  = (st_q == S_LOOK) && q_valid && (!outv_q || pop);
	assign q_take = start;
	assign empty  = !outv_q;
	assign out_word = out_q;

	logic [WayW-1:0] rway_s1;

	always_ff @(posedge clk) begin
		if (start) begin
			op_s1   <= q_word;
			set_s1  <= set_in;
			rdin_s1 <= rin_in;
			rway_s1 <= rway_in;
			for (int w = 0; w < NUM_WAYS; w++) begin
				rd_s2[w]  <= ram_q[w][set_in];
				vrd_s2[w] <= vmem_q[w][set_in];
			end
		end
	end

	// Update stage logic.
	logic [NUM_WAYS-1:0] hit, freev;
	logic                any_hit, any_free;
	logic [WayW-1:0]     hway, fway, uway;
	fcpt_pkg::entry_t    cur, nxt;
	logic                wr_en;
	fcpt_pkg::out_word_t res;

	always_comb begin
		logic [SumW-1:0]  sum;
		logic [TimeW-1:0] span;
		logic             cv;
		hit = '0; freev = '0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			hit[w]   = vrd_s2[w] && (rd_s2[w].addr == op_s1.func_addr);
			freev[w] = !vrd_s2[w];
		end
		any_hit = |hit; any_free = |freev;
		hway = '0; fway = '0;
		for (int w = NUM_WAYS-1; w >= 0; w--) begin
			if (hit[w])   hway = WayW'(w);
			if (freev[w]) fway = WayW'(w);
		end
		uway  = any_hit ? hway : fway;
		cur   = rd_s2[uway];
		cv    = vrd_s2[uway];
		nxt   = cur;
		wr_en = 1'b0;
		res   = '0;
		res.status = fcpt_pkg::ST_EMPTY;
		span  = op_s1.timestamp_us - cur.entry_time;
		sum   = {1'b0, cur.elapsed} + {1'b0, span};
		case (fcpt_pkg::action_t'(op_s1.action))
			fcpt_pkg::ACT_ENTER: begin
				if (!any_hit && !any_free) begin
					res.status = fcpt_pkg::ST_FULL;
					res.entry_addr = op_s1.func_addr;
				end else begin
					if (!any_hit) begin
						nxt = '0;
						nxt.addr = op_s1.func_addr;
					end
					if (nxt.depth == '0) nxt.entry_time = op_s1.timestamp_us;
					if (nxt.depth != '1) nxt.depth = nxt.depth + DepthW'(1);
					if (nxt.calls != '1) nxt.calls = nxt.calls + CallW'(1);
					wr_en = 1'b1;
					res.status = fcpt_pkg::ST_OK;
				end
			end
			fcpt_pkg::ACT_EXIT: begin
				if (!any_hit) begin
					res.status = fcpt_pkg::ST_UNMATCHED;
					res.entry_addr = op_s1.func_addr;
				end else if (cur.depth == '0) begin
					res.status = fcpt_pkg::ST_UNMATCHED;
				end else begin
					nxt.depth = cur.depth - DepthW'(1);
					if (nxt.depth == '0)
						nxt.elapsed = sum[SumW-1] ? '1 : sum[TimeW-1:0];
					wr_en = 1'b1;
					res.status = fcpt_pkg::ST_OK;
				end
			end
			fcpt_pkg::ACT_READ: begin
				cur = rd_s2[rway_s1];
				cv  = vrd_s2[rway_s1];
				nxt = cur;
				if (rdin_s1 && cv) res.status = fcpt_pkg::ST_OK;
			end
			default: res.status = fcpt_pkg::ST_EMPTY;
		endcase
		if (res.status == fcpt_pkg::ST_OK ||
		    (res.status == fcpt_pkg::ST_UNMATCHED && any_hit &&
		     op_s1.action == fcpt_pkg::ACT_EXIT)) begin
			res.entry_addr = nxt.addr;
			res.call_count = nxt.calls;
			res.elapsed_us = nxt.elapsed;
			res.nest_depth = nxt.depth;
		end
	end

	// Clearing pass walks one set per cycle, all ways at once; updates write back the chosen way.
	always_ff @(posedge clk) begin
		if (st_q == S_CLR) begin
			for (int w = 0; w < NUM_WAYS; w++) vmem_q[w][clr_set_q] <= 1'b0;
		end else if (st_q == S_UPD && wr_en) begin
			vmem_q[uway][set_s1] <= 1'b1;
		end
		if (st_q == S_UPD && wr_en) ram_q[uway][set_s1] <= nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_CLR;
			clr_set_q <= '0;
			outv_q    <= 1'b0;
			out_q     <= '0;
		end else begin
			case (st_q)
				S_CLR: begin
					clr_set_q <= clr_set_q + SetW'(1);
					if (clr_set_q == SetW'(NUM_SETS - 1)) st_q <= S_LOOK;
				end
				S_LOOK: begin
					if (pop) outv_q <= 1'b0;
					if (start) st_q <= S_UPD;
				end
				S_UPD: begin
					outv_q <= 1'b1;
					out_q  <= res;
					st_q   <= S_LOOK;
				end
				default: st_q <= S_LOOK;
			endcase
		end
	end

	`FCP_ASSERT_NEXT(a_upd_follows, clk, arst_n, start, st_q == S_UPD, "lookup not followed by update")
	`FCP_ASSERT_ALWAYS(a_no_take_busy, clk, arst_n, !(q_take && st_q != S_LOOK), "took word while busy")
	`FCP_ASSERT_NEXT(a_result_out, clk, arst_n, st_q == S_UPD, !empty, "result not presented")
	`FCP_ASSERT_ALWAYS(a_hit_onehot, clk, arst_n, !(st_q == S_UPD) || $onehot0(hit), "multiple ways hit")
endmodule
`default_nettype wire

### hdl/function_call_profiler_table_core.sv
`default_nettype none
// Per-function call profiler table. Enter/exit words carry a 48-bit
// function address and a microsecond timestamp; read words fetch one slot
// (set*NUM_WAYS+way). Every accepted word produces exactly one result word.
// A set-associative table (set = addr mod NUM_SETS) holds per function the
// call count, nesting depth, outermost entry time and accumulated time.
// In the table engine an input word first has all ways of its set read
// from the per-way memories, then is compared, updated and written back;
// the engine handles one word at a time. A 2-entry input queue keeps push
// open while the engine works; the result register holds one finished
// word until popped, and the engine waits while it is full. Valid bits
// live in per-way memories: after reset a clearing pass walks all
// NUM_SETS sets, one set per cycle; the input queue still takes up to two
// words during it, then holds full until the pass is done.
module function_call_profiler_table_core #(
	parameter int unsigned NUM_SETS = fcpt_pkg::NumSetsDef,
	parameter int unsigned NUM_WAYS = fcpt_pkg::NumWaysDef
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      push,
	output logic                     full,
	input  wire fcpt_pkg::in_word_t  in_word,
	output logic                     empty,
	input  wire                      pop,
	output fcpt_pkg::out_word_t      out_word
);
	logic               q_valid, q_take;
	fcpt_pkg::in_word_t q_word;

	fcpt_front u_front (
		.clk, .arst_n, .push, .full, .in_word,
		.q_valid, .q_take, .q_word
	);

	fcpt_back #(.NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS)) u_back (
		.clk, .arst_n, .q_valid, .q_take, .q_word,
		.empty, .pop, .out_word
	);
endmodule
`default_nettype wire

### tb/profiler_checker.sv
module profiler_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic                full,
	input  fcpt_pkg::in_word_t  in_word,
	input  logic                empty,
	input  logic                pop,
	input  fcpt_pkg::out_word_t out_word,
	output int                  fail_count,
	output int                  pending
);
	import fcpt_pkg::*;

	localparam int unsigned SLOTS = NumSetsDef * NumWaysDef;
	localparam logic [TimeW-1:0] TIME_MAX = '1;
	localparam logic [CallW-1:0] CALL_MAX = '1;
	localparam logic [DepthW-1:0] DEPTH_MAX = '1;

	logic   tbl_valid [SLOTS];
	entry_t tbl       [SLOTS];
	out_word_t want_q [$];

	initial fail_count = 0;
	assign pending = want_q.size();

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
		$display("mismatch %s: got %h want %h at %0t", what, got, exp, $time);
		fail_count++;
	endtask

	function automatic int find_way(input logic [AddrW-1:0] a, input bit want_free);
		int b;
		b = int'(a % NumSetsDef) * NumWaysDef;
		for (int w = 0; w < NumWaysDef; w++) begin
			if (want_free && !tbl_valid[b+w]) return b + w;
			if (!want_free && tbl_valid[b+w] && tbl[b+w].addr == a) return b + w;
		end
		return -1;
	endfunction

	function automatic out_word_t show(input logic [1:0] st, input int s);
		out_word_t o;
		o.status = st;
		o.entry_addr = tbl[s].addr;
		o.call_count = tbl[s].calls;
		o.elapsed_us = tbl[s].elapsed;
		o.nest_depth = tbl[s].depth;
		return o;
	endfunction

	function automatic out_word_t profile_step(input in_word_t w);
		out_word_t o;
		int s;
		logic [TimeW:0] sum;
		o = '0;
		o.status = ST_EMPTY;
		case (action_t'(w.action))
			ACT_ENTER: begin
				s = find_way(w.func_addr, 0);
				if (s < 0) begin
					s = find_way(w.func_addr, 1);
					if (s < 0) begin
						o.status = ST_FULL;
						o.entry_addr = w.func_addr;
						return o;
					end
					tbl_valid[s] = 1'b1;
					tbl[s] = '0;
					tbl[s].addr = w.func_addr;
				end
				if (tbl[s].depth == 0) tbl[s].entry_time = w.timestamp_us;
				if (tbl[s].depth != DEPTH_MAX) tbl[s].depth++;
				if (tbl[s].calls != CALL_MAX) tbl[s].calls++;
				o = show(ST_OK, s);
			end
			ACT_EXIT: begin
				s = find_way(w.func_addr, 0);
				if (s < 0) begin
					o.status = ST_UNMATCHED;
					o.entry_addr = w.func_addr;
				end else if (tbl[s].depth == 0) begin
					o = show(ST_UNMATCHED, s);
				end else begin
					tbl[s].depth--;
					if (tbl[s].depth == 0) begin
						// span wraps mod 2^48, sum saturates
						sum = {1'b0, tbl[s].elapsed}
							+ {1'b0, TimeW'(w.timestamp_us - tbl[s].entry_time)};
						tbl[s].elapsed = sum[TimeW] ? TIME_MAX : sum[TimeW-1:0];
					end
					o = show(ST_OK, s);
				end
			end
			ACT_READ: begin
				if (w.slot_index < SLOTS && tbl_valid[w.slot_index])
					o = show(ST_OK, int'(w.slot_index));
			end
			default: ;
		endcase
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_word_t e;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;
			want_q.delete();
		end else begin
			if (push && !full) want_q.push_back(profile_step(in_word));
			if (pop && !empty) begin
				if (want_q.size() == 0) begin
					report("unexpected word", 64'(out_word.status), 64'd0);
				end else begin
					e = want_q.pop_front();
					if (out_word.status != e.status)
						report("status", 64'(out_word.status), 64'(e.status));
					if (out_word.entry_addr != e.entry_addr)
						report("entry_addr", 64'(out_word.entry_addr), 64'(e.entry_addr));
					if (out_word.call_count != e.call_count)
						report("call_count", 64'(out_word.call_count), 64'(e.call_count));
					if (out_word.elapsed_us != e.elapsed_us)
						report("elapsed_us", 64'(out_word.elapsed_us), 64'(e.elapsed_us));
					if (out_word.nest_depth != e.nest_depth)
						report("nest_depth", 64'(out_word.nest_depth), 64'(e.nest_depth));
				end
			end
		end
	end
endmodule

### tb/tb.sv
module tb;
	import fcpt_pkg::*;

	logic clk, arst_n, push, pop, full, empty;
	in_word_t in_word;
	out_word_t out_word;
	int fail_count, pending;

	// Stimulus-side model of which addresses are live, to steer exits
	logic [AddrW-1:0] live_addr [$];
	logic [TimeW-1:0] now_us;
	int n_sent;

	function_call_profiler_table_core i_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_word(in_word),
		.empty(empty), .pop(pop), .out_word(out_word)
	);

	profiler_checker i_chk (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_word(in_word),
		.empty(empty), .pop(pop), .out_word(out_word),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		clk = 1'b0; #6;
		clk = 1'b1; #6;
	end

	// Hard stop; slowest run is far below this.
	initial begin
		#3000000;
		$display("timeout");
		$display("CHECK FAILED");
		$finish;
	end

	// Receiver: stall pattern drifts between modes, including no stalls.
	initial begin
		int mode;
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 3);
			case (mode)
				0: pop <= 1'b1;
				1: pop <= $urandom_range(0, 3) != 0;
				2: pop <= $urandom_range(0, 3) == 0;
				default: pop <= ~pop;
			endcase
		end
	end

	// Hold one word on the input until accepted; push stays high so the
	// next word can follow directly, gap() drops it.
	task automatic send_word(input logic [1:0] act, input logic [AddrW-1:0] a,
		input logic [TimeW-1:0] ts, input logic [IdxW-1:0] idx);
		push <= 1'b1;
		in_word <= '{action: act, func_addr: a, timestamp_us: ts, slot_index: idx};
		do @(posedge clk); while (full);
		@(negedge clk);
		n_sent++;
	endtask

	task automatic gap();
		push <= 1'b0;
		repeat ($urandom_range(1, 6)) @(negedge clk);
	endtask

	initial begin
		logic [AddrW-1:0] a;
		logic [AddrW-1:0] hot;
		int burst;
		push = 1'b0;
		in_word = '0;
		arst_n = 1'b0;
		n_sent = 0;
		now_us = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: extremes, set overflow, unmatched exits, wrap, reads.
		send_word(ACT_EXIT, 48'h1234, 48'd5, '0);                 // unknown exit
		send_word(ACT_ENTER, '1, '1, '1);                           // max fields
		send_word(ACT_EXIT, '1, 48'd9, '0);                         // wrapped span
		send_word(ACT_EXIT, '1, 48'd10, '0);                        // exit at depth 0
		for (int i = 0; i < 5; i++)                                 // fifth overflows set 0
			send_word(ACT_ENTER, 48'(i * NumSetsDef), 48'd100, '0);
		send_word(ACT_ENTER, '0, 48'd200, '0);                      // nested
		send_word(ACT_EXIT, '0, 48'd300, '0);
		send_word(ACT_EXIT, '0, 48'd400, '0);
		send_word(ACT_READ, '0, '0, 12'd0);
		send_word(ACT_READ, '0, '0, 12'd3);
		send_word(ACT_READ, '0, '0, 12'd5);                         // empty slot
		send_word(ACT_READ, '1, '1, '1);                            // last slot
		send_word(ACT_NONE, '1, '1, '1);
		send_word(ACT_EXIT, 48'h0000_ffff_0000, '0, '0);
		send_word(ACT_ENTER, 48'hffff_0000_ffff, 48'hffff_ffff_fff0, '0);
		send_word(ACT_EXIT, 48'hffff_0000_ffff, 48'h20, '0);

		// Random: mostly nested enter/exit on a small address pool
		hot = 48'($urandom()) << 10;
		while (n_sent < 900) begin
			burst = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
			repeat (burst) begin
				now_us += $urandom_range(0, 500);
				case ($urandom_range(0, 19))
					0, 1, 2, 3, 4, 5: begin
						a = ($urandom_range(0, 3) == 0) ? {$urandom(), 16'($urandom())}
							: hot + 48'($urandom_range(0, 5) * NumSetsDef + $urandom_range(0, 2));
						live_addr.push_back(a);
						send_word(ACT_ENTER, a, now_us, 12'($urandom()));
					end
					6, 7, 8, 9, 10: begin
						a = live_addr.size() ? live_addr[$urandom_range(0, live_addr.size()-1)]
							: hot;
						send_word(ACT_EXIT, a, now_us, 12'($urandom()));
					end
					11, 12, 13: send_word(ACT_READ, {$urandom(), 16'($urandom())}, now_us,
						12'((hot % NumSetsDef) * NumWaysDef + $urandom_range(0, 23)));
					14: send_word(ACT_READ, {$urandom(), 16'($urandom())},
						{$urandom(), 16'($urandom())}, 12'($urandom()));
					15: send_word(ACT_NONE, {$urandom(), 16'($urandom())},
						{$urandom(), 16'($urandom())}, 12'($urandom()));
					16: send_word(ACT_EXIT, {$urandom(), 16'($urandom())},
						{$urandom(), 16'($urandom())}, 12'($urandom()));
					default: begin
						// jump the clock far to exercise wrap and big spans
						now_us += {$urandom(), 16'($urandom())};
						send_word(ACT_ENTER, hot, now_us, 12'($urandom()));
					end
				endcase
			end
			if ($urandom_range(0, 2) != 0) gap();
		end
		push <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		$display("sent %0d words: nested enter/exit, set overflow, wrap, slot reads", n_sent);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
